>>> design/tiu_pkg.sv
// Package for the timer and interrupt unit.
// Holds the item types, command and register codes, timing constants and helpers.
// No dependencies.
package tiu_pkg;

   typedef enum logic [1:0] {
      CMD_STEP  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   localparam logic [2:0] REG_DIV  = 3'd0;
   localparam logic [2:0] REG_TIMA = 3'd1;
   localparam logic [2:0] REG_TMA  = 3'd2;
   localparam logic [2:0] REG_TAC  = 3'd3;
   localparam logic [2:0] REG_IF   = 3'd4;
   localparam logic [2:0] REG_IE   = 3'd5;

   localparam logic [15:0] DIV_PERIOD     = 16'd256;
   localparam logic [15:0] TIMER_PER_1024 = 16'd1024;
   localparam logic [15:0] TIMER_PER_16   = 16'd16;
   localparam logic [15:0] TIMER_PER_64   = 16'd64;
   localparam logic [15:0] TIMER_PER_256  = 16'd256;
   localparam logic [15:0] DISPATCH_CYCLES = 16'd20;
   localparam logic [7:0]  TIMA_MAX       = 8'hFF;
   localparam logic [6:0]  VECTOR_BASE    = 7'h40;
   localparam logic [2:0]  TIMER_SOURCE   = 3'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [2:0] reg_sel;
      logic [7:0] wdata;
      logic [7:0] elapsed_cycles;
      logic       master_enable;
      logic [4:0] external_requests;
   } req_item_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       taken;
      logic [6:0] vector;
      logic       wake;
      logic       timer_overflowed;
   } rsp_item_type;

   function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

   function automatic logic [15:0] timer_period(input logic [1:0] sel);
      logic [15:0] per;
      case (sel)
         2'd0:    per = TIMER_PER_1024;
         2'd1:    per = TIMER_PER_16;
         2'd2:    per = TIMER_PER_64;
         default: per = TIMER_PER_256;
      endcase
      return per;
   endfunction

endpackage

>>> design/tiu_channels.sv
// Handshake channel interfaces for the timer and interrupt unit.
// One interface for request words and one for response words; no dependencies.
interface tiu_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [2:0] reg_sel;
   logic [7:0] wdata;
   logic [7:0] elapsed_cycles;
   logic       master_enable;
   logic [4:0] external_requests;

   modport source (output valid, output cmd, output reg_sel, output wdata,
                   output elapsed_cycles, output master_enable,
                   output external_requests, input ready);
   modport sink (input valid, input cmd, input reg_sel, input wdata,
                 input elapsed_cycles, input master_enable,
                 input external_requests, output ready);
endinterface

interface tiu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] rdata;
   logic       taken;
   logic [6:0] vector;
   logic       wake;
   logic       timer_overflowed;

   modport source (output valid, output rdata, output taken, output vector,
                   output wake, output timer_overflowed, input ready);
   modport sink (input valid, input rdata, input taken, input vector,
                 input wake, input timer_overflowed, output ready);
endinterface

>>> design/tiu_core.sv
// Register file and update logic of the timer and interrupt unit.
// Holds DIV, TIMA, TMA, TAC, IF, IE and the cycle counters; uses tiu_pkg.
module tiu_core
   import tiu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [7:0]  divider_ff, divider_in;
   logic [7:0]  timer_count_ff, timer_count_in;
   logic [7:0]  timer_modulo_ff, timer_modulo_in;
   logic [2:0]  timer_control_ff, timer_control_in;
   logic [4:0]  interrupt_flags_ff, interrupt_flags_in;
   logic [7:0]  interrupt_enables_ff, interrupt_enables_in;
   logic [15:0] divider_cycles_ff, divider_cycles_in;
   logic [15:0] timer_cycles_ff, timer_cycles_in;

   logic [15:0] period;
   logic [4:0]  pending;
   logic [2:0]  source;

   always_comb begin
      divider_in           = divider_ff;
      timer_count_in       = timer_count_ff;
      timer_modulo_in      = timer_modulo_ff;
      timer_control_in     = timer_control_ff;
      interrupt_flags_in   = interrupt_flags_ff;
      interrupt_enables_in = interrupt_enables_ff;
      divider_cycles_in    = divider_cycles_ff;
      timer_cycles_in      = timer_cycles_ff;
      result               = '0;
      period               = timer_period(timer_control_ff[1:0]);
      pending              = '0;
      source               = '0;

      unique case (item.cmd)
         CMD_STEP: begin
            interrupt_flags_in = interrupt_flags_ff | item.external_requests;
            divider_cycles_in  = sat_add16(divider_cycles_ff, {8'd0, item.elapsed_cycles});
            timer_cycles_in    = sat_add16(timer_cycles_ff, {8'd0, item.elapsed_cycles});
            if (divider_cycles_in >= DIV_PERIOD) begin
               divider_in        = divider_ff + 8'd1;
               divider_cycles_in = divider_cycles_in - DIV_PERIOD;
            end
            if (timer_control_ff[2] && (timer_cycles_in >= period)) begin
               if (timer_count_ff == TIMA_MAX) begin
                  timer_count_in                   = timer_modulo_ff;
                  interrupt_flags_in[TIMER_SOURCE] = 1'b1;
                  result.timer_overflowed          = 1'b1;
               end else begin
                  timer_count_in = timer_count_ff + 8'd1;
               end
               timer_cycles_in = timer_cycles_in - period;
            end
            pending     = interrupt_enables_ff[4:0] & interrupt_flags_in;
            result.wake = |pending;
            for (int k = 4; k >= 0; k--) begin
               if (pending[k]) begin
                  source = 3'(k);
               end
            end
            if (item.master_enable && (|pending)) begin
               interrupt_flags_in[source] = 1'b0;
               result.taken               = 1'b1;
               result.vector              = VECTOR_BASE + {1'b0, source, 3'b000};
               divider_cycles_in          = sat_add16(divider_cycles_in, DISPATCH_CYCLES);
               timer_cycles_in            = sat_add16(timer_cycles_in, DISPATCH_CYCLES);
            end
         end
         CMD_WRITE: begin
            unique case (item.reg_sel)
               REG_DIV:  divider_in           = '0;
               REG_TIMA: timer_count_in       = item.wdata;
               REG_TMA:  timer_modulo_in      = item.wdata;
               REG_TAC:  timer_control_in     = item.wdata[2:0];
               REG_IF:   interrupt_flags_in   = item.wdata[4:0];
               REG_IE:   interrupt_enables_in = item.wdata;
               default: ;
            endcase
            result.wake = |(interrupt_enables_in[4:0] & interrupt_flags_in);
         end
         CMD_READ: begin
            unique case (item.reg_sel)
               REG_DIV:  result.rdata = divider_ff;
               REG_TIMA: result.rdata = timer_count_ff;
               REG_TMA:  result.rdata = timer_modulo_ff;
               REG_TAC:  result.rdata = {5'd0, timer_control_ff};
               REG_IF:   result.rdata = {3'd0, interrupt_flags_ff};
               REG_IE:   result.rdata = interrupt_enables_ff;
               default:  result.rdata = '0;
            endcase
            result.wake = |(interrupt_enables_ff[4:0] & interrupt_flags_ff);
         end
         default: begin
            result.wake = |(interrupt_enables_ff[4:0] & interrupt_flags_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff           <= '0;
         timer_count_ff       <= '0;
         timer_modulo_ff      <= '0;
         timer_control_ff     <= '0;
         interrupt_flags_ff   <= '0;
         interrupt_enables_ff <= '0;
         divider_cycles_ff    <= '0;
         timer_cycles_ff      <= '0;
      end else if (fire) begin
         divider_ff           <= divider_in;
         timer_count_ff       <= timer_count_in;
         timer_modulo_ff      <= timer_modulo_in;
         timer_control_ff     <= timer_control_in;
         interrupt_flags_ff   <= interrupt_flags_in;
         interrupt_enables_ff <= interrupt_enables_in;
         divider_cycles_ff    <= divider_cycles_in;
         timer_cycles_ff      <= timer_cycles_in;
      end
   end

`ifndef SYNTHESIS
   a_taken_needs_wake: assert property (@(posedge clock) disable iff (reset)
      fire && result.taken |-> result.wake)
      else $error("interrupt dispatched without a pending enabled source");

   a_overflow_reloads: assert property (@(posedge clock) disable iff (reset)
      fire && result.timer_overflowed |=> timer_count_ff == $past(timer_modulo_ff))
      else $error("timer overflow did not reload the modulo value");

   a_rdata_only_on_read: assert property (@(posedge clock) disable iff (reset)
      fire && (item.cmd != CMD_READ) |-> result.rdata == 8'd0)
      else $error("read data driven on a non-read command");
`endif

endmodule

>>> design/timer_and_interrupt_unit.sv
// Timer and interrupt unit: one response word per request word.
// A request word is registered in the input stage, then its response word is registered in the output stage.
// Throughput is one word per cycle while the response channel does not stall.
// Synchronous active-high reset clears the unit's state and the valid flags of both stages.
// Uses tiu_pkg, tiu_req_if, tiu_rsp_if and tiu_core.
module timer_and_interrupt_unit
   import tiu_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   tiu_req_if.sink   req_ch,
   tiu_rsp_if.source rsp_ch
);

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type core_result;
   logic         advance;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_item_ff.cmd               <= req_ch.cmd;
         in_item_ff.reg_sel           <= req_ch.reg_sel;
         in_item_ff.wdata             <= req_ch.wdata;
         in_item_ff.elapsed_cycles    <= req_ch.elapsed_cycles;
         in_item_ff.master_enable     <= req_ch.master_enable;
         in_item_ff.external_requests <= req_ch.external_requests;
      end
   end

   tiu_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.rdata            = out_item_ff.rdata;
   assign rsp_ch.taken            = out_item_ff.taken;
   assign rsp_ch.vector           = out_item_ff.vector;
   assign rsp_ch.wake             = out_item_ff.wake;
   assign rsp_ch.timer_overflowed = out_item_ff.timer_overflowed;

endmodule
